### sv/udp_ipv4_header_builder_unit_defines.svh
// Assertion helpers for the block's top-level unit.
`ifndef UDP_IPV4_HEADER_BUILDER_UNIT_DEFINES_SVH
`define UDP_IPV4_HEADER_BUILDER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UDPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udpb assertion failed");

// next-cycle implication, disabled in reset
`define UDPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udpb assertion failed");

`endif

### sv/udpb_pkg.sv
package udpb_pkg;

  localparam logic [15:0] MAX_PAYLOAD_BYTES = 16'd65507;

  localparam logic [15:0] IP_LEN_OFFSET  = 16'd28;  // IPv4 + UDP header bytes
  localparam logic [15:0] UDP_LEN_OFFSET = 16'd8;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] IP_VER_TOS     = 16'h4500;
  localparam logic [15:0] IP_FLAGS       = 16'h4000;
  localparam logic [15:0] CKSUM_ALL_ONES = 16'hFFFF;

  // fixed words of the IPv4 header checksum, protocol byte included
  localparam logic [17:0] IP_CONST_SUM =
    18'(IP_VER_TOS) + 18'(IP_FLAGS) + 18'(PROTO_UDP);

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ADDRESS      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION_ADDRESS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PORT         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION_PORT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_TO_LIVE        = 3'd4;

  localparam logic [31:0] RST_SOURCE_ADDRESS      = 32'h0606_0600;
  localparam logic [31:0] RST_DESTINATION_ADDRESS = 32'h0;
  localparam logic [15:0] RST_SOURCE_PORT         = 16'd6666;
  localparam logic [15:0] RST_DESTINATION_PORT    = 16'd0;
  localparam logic [7:0]  RST_TIME_TO_LIVE        = 8'd50;

  // header word positions
  localparam logic [3:0] W_VER_TOS   = 4'd0;
  localparam logic [3:0] W_TOT_LEN   = 4'd1;
  localparam logic [3:0] W_IDENT     = 4'd2;
  localparam logic [3:0] W_FLAGS     = 4'd3;
  localparam logic [3:0] W_TTL_PROTO = 4'd4;
  localparam logic [3:0] W_HDR_CK    = 4'd5;
  localparam logic [3:0] W_SA_HI     = 4'd6;
  localparam logic [3:0] W_SA_LO     = 4'd7;
  localparam logic [3:0] W_DA_HI     = 4'd8;
  localparam logic [3:0] W_DA_LO     = 4'd9;
  localparam logic [3:0] W_SPORT     = 4'd10;
  localparam logic [3:0] W_DPORT     = 4'd11;
  localparam logic [3:0] W_UDP_LEN   = 4'd12;
  localparam logic [3:0] W_UDP_CK    = 4'd13;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [3:0]  word_index;
    logic        length_error;
    logic        end_of_header;
  } result_t;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  time_to_live;
  } cfg_t;

  // one finished datagram handed from front to back
  typedef struct packed {
    logic [15:0] payload_sum;
    logic [15:0] byte_count;
    logic        overflow;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } jobq_status_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // end-around fold of a wide plain sum down to 16 bits
  function automatic logic [15:0] oc_fold(input logic [19:0] x);
    logic [16:0] t;
    t = {1'b0, x[15:0]} + {13'd0, x[19:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

### sv/udpb_front.sv
module udpb_front
  import udpb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output logic  job_push,
  output job_t  job
);

  logic [15:0] payload_sum;
  logic [15:0] byte_count;
  logic [7:0]  held_high_byte;
  logic        odd_position;
  logic        overflow_seen;

  logic [15:0] pair_word;
  logic [15:0] sum_next;
  logic [15:0] count_next;
  logic        overflow_next;

  // an odd final byte is padded low, so one adder serves both cases
  assign pair_word     = odd_position ? {held_high_byte, item.payload_byte}
                                      : {item.payload_byte, 8'h00};
  assign sum_next      = oc_add(payload_sum, pair_word);
  assign count_next    = (byte_count < MAX_PAYLOAD_BYTES) ? byte_count + 16'd1
                                                          : byte_count;
  assign overflow_next = overflow_seen | (byte_count >= MAX_PAYLOAD_BYTES);

  assign job_push        = accept & item.final_byte;
  assign job.payload_sum = sum_next;
  assign job.byte_count  = count_next;
  assign job.overflow    = overflow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_sum    <= '0;
      byte_count     <= '0;
      held_high_byte <= '0;
      odd_position   <= 1'b0;
      overflow_seen  <= 1'b0;
    end else if (accept) begin
      if (item.final_byte) begin
        payload_sum    <= '0;
        byte_count     <= '0;
        held_high_byte <= '0;
        odd_position   <= 1'b0;
        overflow_seen  <= 1'b0;
      end else begin
        byte_count    <= count_next;
        overflow_seen <= overflow_next;
        if (odd_position) begin
          payload_sum    <= sum_next;
          held_high_byte <= '0;
          odd_position   <= 1'b0;
        end else begin
          held_high_byte <= item.payload_byte;
          odd_position   <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/udpb_jobq.sv
module udpb_jobq
  import udpb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  job_t         push_job,
  input  logic         pop,
  output job_t         head_job,
  output jobq_status_t status
);

  job_t               entries [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr;
  logic [JOBQ_AW-1:0] rd_ptr;
  logic [JOBQ_AW:0]   count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign status.valid = (count != '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & status.valid;
  assign head_job     = entries[rd_ptr];

  function automatic logic [JOBQ_AW-1:0] ptr_inc(input logic [JOBQ_AW-1:0] p);
    return (p == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : p + JOBQ_AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (JOBQ_AW+1)'(1);
        2'b01:   count <= count - (JOBQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/udpb_back.sv
module udpb_back
  import udpb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_pop,
  input  cfg_t    cfg,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic        active;
  logic [3:0]  idx;
  logic        st1;
  logic        st2;
  logic        st3;
  logic        ck_done;

  logic [15:0] payload_sum;
  logic        overflow;
  logic [15:0] ip_len;
  logic [15:0] udp_len;
  logic [17:0] addr_sum;
  logic [17:0] misc_ip;
  logic [17:0] misc_udp;
  logic [19:0] ip_raw;
  logic [19:0] udp_raw;
  logic [15:0] ip_ck;
  logic [15:0] udp_ck;

  logic        out_valid;
  result_t     out_reg;

  logic        can_emit;
  logic        last_word;
  logic        load;
  logic [15:0] word;
  logic [15:0] udp_ck_raw;

  // words from the header checksum on wait for the checksum pipeline
  assign can_emit  = active & (~out_valid | pop) & ((idx < W_HDR_CK) | ck_done);
  assign last_word = can_emit & (idx == W_UDP_CK);
  assign load      = job_valid & (~active | last_word);
  assign job_pop   = load;

  assign empty  = ~out_valid;
  assign result = out_reg;

  assign udp_ck_raw = ~oc_fold(udp_raw);

  always_comb begin
    unique case (idx)
      W_VER_TOS:   word = IP_VER_TOS;
      W_TOT_LEN:   word = ip_len;
      W_IDENT:     word = 16'h0000;
      W_FLAGS:     word = IP_FLAGS;
      W_TTL_PROTO: word = {cfg.time_to_live, PROTO_UDP};
      W_HDR_CK:    word = ip_ck;
      W_SA_HI:     word = cfg.source_address[31:16];
      W_SA_LO:     word = cfg.source_address[15:0];
      W_DA_HI:     word = cfg.destination_address[31:16];
      W_DA_LO:     word = cfg.destination_address[15:0];
      W_SPORT:     word = cfg.source_port;
      W_DPORT:     word = cfg.destination_port;
      W_UDP_LEN:   word = udp_len;
      W_UDP_CK:    word = udp_ck;
      default:     word = 16'h0000;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      st1       <= 1'b0;
      st2       <= 1'b0;
      st3       <= 1'b0;
      ck_done   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st1 <= load;
      st2 <= st1;
      st3 <= st2;
      if (load) begin
        ck_done <= 1'b0;
      end else if (st3) begin
        ck_done <= 1'b1;
      end

      if (load) begin
        active <= 1'b1;
        idx    <= W_VER_TOS;
      end else if (last_word) begin
        active <= 1'b0;
      end else if (can_emit) begin
        idx <= idx + 4'd1;
      end

      if (can_emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checksum pipeline, one step per cycle after a job is taken
  always_ff @(posedge clk) begin
    if (load) begin
      payload_sum <= job.payload_sum;
      overflow    <= job.overflow;
      ip_len      <= job.byte_count + IP_LEN_OFFSET;
      udp_len     <= job.byte_count + UDP_LEN_OFFSET;
    end
    if (st1) begin
      addr_sum <= 18'(cfg.source_address[31:16]) + 18'(cfg.source_address[15:0])
                + 18'(cfg.destination_address[31:16])
                + 18'(cfg.destination_address[15:0]);
      misc_ip  <= 18'(ip_len) + 18'({cfg.time_to_live, 8'h00}) + IP_CONST_SUM;
      misc_udp <= 18'(payload_sum) + 18'(cfg.source_port)
                + 18'(cfg.destination_port) + 18'(PROTO_UDP);
    end
    if (st2) begin
      ip_raw  <= 20'(addr_sum) + 20'(misc_ip);
      // UDP length enters the sum twice: header field and pseudo-header
      udp_raw <= 20'(addr_sum) + 20'(misc_udp) + 20'({udp_len, 1'b0});
    end
    if (st3) begin
      ip_ck  <= ~oc_fold(ip_raw);
      udp_ck <= (udp_ck_raw == 16'h0000) ? CKSUM_ALL_ONES : udp_ck_raw;
    end
    if (can_emit) begin
      out_reg.header_word   <= word;
      out_reg.word_index    <= idx;
      out_reg.length_error  <= overflow;
      out_reg.end_of_header <= (idx == W_UDP_CK);
    end
  end

endmodule

### sv/udp_ipv4_header_builder_unit.sv
// Builds the IPv4 and UDP headers for a datagram whose payload streams in one
// byte per beat. Payload bytes are taken every cycle while full is low; the
// running ones' complement sum is a single 16-bit end-around adder in the
// front. The byte marked final hands the datagram's sum and length to a job
// queue of JOBQ_DEPTH entries, and full is high only while that queue is
// full. The back end then puts out the fourteen header words, one per cycle
// while pop is held; the two checksums come from a three-step add and fold
// pipeline that runs alongside the first words. Input and output work on
// different datagrams at once, and the slower of the two sets the throughput.
// Configuration writes are expected only while no datagram is in flight.
`include "udp_ipv4_header_builder_unit_defines.svh"

module udp_ipv4_header_builder_unit
  import udpb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  item_t                  item,
  output logic                   empty,
  input  logic                   pop,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t         cfg;
  jobq_status_t jq_status;
  logic         job_push;
  job_t         front_job;
  job_t         head_job;
  logic         job_pop;
  logic         accept;

  assign full   = jq_status.full;
  assign accept = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_address      <= RST_SOURCE_ADDRESS;
      cfg.destination_address <= RST_DESTINATION_ADDRESS;
      cfg.source_port         <= RST_SOURCE_PORT;
      cfg.destination_port    <= RST_DESTINATION_PORT;
      cfg.time_to_live        <= RST_TIME_TO_LIVE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_ADDRESS:      cfg.source_address      <= cfg_data;
        REG_DESTINATION_ADDRESS: cfg.destination_address <= cfg_data;
        REG_SOURCE_PORT:         cfg.source_port         <= cfg_data[15:0];
        REG_DESTINATION_PORT:    cfg.destination_port    <= cfg_data[15:0];
        REG_TIME_TO_LIVE:        cfg.time_to_live        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  udpb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (front_job)
  );

  udpb_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .pop      (job_pop),
    .head_job (head_job),
    .status   (jq_status)
  );

  udpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (jq_status.valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .cfg       (cfg),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  // within a header run the next word follows at once
  `UDPB_ASSERT_NEXT(a_run_continues, !empty && pop && !result.end_of_header,
    !empty && result.word_index == $past(result.word_index) + 4'd1)
  // the error flag is the same on every word of a run
  `UDPB_ASSERT_NEXT(a_error_steady, !empty && pop && !result.end_of_header,
    result.length_error == $past(result.length_error))
  // end of header marks exactly the last word
  `UDPB_ASSERT_NOW(a_end_marks_last, !empty,
    result.end_of_header == (result.word_index == W_UDP_CK))

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import udpb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          PHASE_BYTES  = 89;
  localparam int          SETTLE_WAIT  = 20;

  localparam logic [15:0] VER_IHL_TOS   = 16'h4500;
  localparam logic [15:0] DONT_FRAGMENT = 16'h4000;
  localparam logic [7:0]  UDP_PROTOCOL  = 8'd17;
  localparam logic [15:0] IPV4_HDR_LEN  = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [15:0] ZERO_CK_SENT  = 16'hFFFF;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_TIME_TO_LIVE + CFG_INDEX_W'(1);

  // one row of the directed plan: the byte is repeated, last marks only the final repeat
  typedef struct packed {
    logic [7:0]  value;
    logic        last;
    int unsigned reps;
    logic        pinned;
    logic [3:0]  pin_index;
    logic [15:0] pin_word;
    logic        pin_lerr;
  } plan_row_t;

  localparam plan_row_t PLAN [0:11] = '{
    '{8'h00, 1'b1, 1,     1'b1, W_TOT_LEN, 16'd29,   1'b0},  // single zero byte
    '{8'hFF, 1'b1, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'hD9, 1'b0, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'hCA, 1'b1, 1,     1'b1, W_UDP_CK,  16'hFFFF, 1'b0},  // checksum computes to zero, sent as FFFF
    '{8'h80, 1'b0, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'h01, 1'b0, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'hFF, 1'b1, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},  // odd length, pad low
    '{8'hFF, 1'b0, 3,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'hFF, 1'b1, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'h00, 1'b0, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'h00, 1'b1, 1,     1'b0, W_VER_TOS, 16'h0000, 1'b0},
    '{8'h7E, 1'b1, 1,     1'b1, W_TOT_LEN, 16'd29,   1'b0}   // state cleared afterwards
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  item_t                  item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                result;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  udp_ipv4_header_builder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state: registers and running datagram
  logic [31:0] src_addr = RST_SOURCE_ADDRESS;
  logic [31:0] dst_addr = RST_DESTINATION_ADDRESS;
  logic [15:0] src_port = RST_SOURCE_PORT;
  logic [15:0] dst_port = RST_DESTINATION_PORT;
  logic [7:0]  ttl      = RST_TIME_TO_LIVE;
  logic [15:0] pay_sum  = '0;
  logic [15:0] nbytes   = '0;
  logic [7:0]  held_hi  = '0;
  logic        odd_pos  = 1'b0;
  logic        ovf      = 1'b0;

  result_t header_words_due [$];

  int fail_count    = 0;
  int words_checked = 0;
  int datagrams     = 0;
  int bytes_sent    = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_ticket   = 0;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] fold_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // absorb one payload byte; on the final byte queue the fourteen header words
  task automatic absorb_byte(item_t it);
    logic [15:0] w [14];
    logic [15:0] udp_len;
    logic [15:0] acc;
    result_t     r;
    if (odd_pos) begin
      pay_sum = fold_add(pay_sum, {held_hi, it.payload_byte});
      held_hi = '0;
      odd_pos = 1'b0;
    end else begin
      held_hi = it.payload_byte;
      odd_pos = 1'b1;
    end
    if (nbytes < MAX_PAYLOAD_BYTES) nbytes = nbytes + 16'd1;
    else ovf = 1'b1;
    if (!it.final_byte) return;

    if (odd_pos) pay_sum = fold_add(pay_sum, {held_hi, 8'h00});
    udp_len = UDP_HDR_LEN + nbytes;
    w[W_VER_TOS]   = VER_IHL_TOS;
    w[W_TOT_LEN]   = IPV4_HDR_LEN + UDP_HDR_LEN + nbytes;
    w[W_IDENT]     = '0;
    w[W_FLAGS]     = DONT_FRAGMENT;
    w[W_TTL_PROTO] = {ttl, UDP_PROTOCOL};
    w[W_HDR_CK]    = '0;
    w[W_SA_HI]     = src_addr[31:16];
    w[W_SA_LO]     = src_addr[15:0];
    w[W_DA_HI]     = dst_addr[31:16];
    w[W_DA_LO]     = dst_addr[15:0];
    acc = '0;
    for (int k = 0; k < 10; k++) acc = fold_add(acc, w[k]);
    w[W_HDR_CK] = ~acc;
    w[W_SPORT]   = src_port;
    w[W_DPORT]   = dst_port;
    w[W_UDP_LEN] = udp_len;
    // pseudo-header, UDP header and payload
    acc = pay_sum;
    for (int k = W_SA_HI; k <= W_DA_LO; k++) acc = fold_add(acc, w[k]);
    acc = fold_add(acc, {8'h00, UDP_PROTOCOL});
    acc = fold_add(acc, udp_len);
    acc = fold_add(acc, src_port);
    acc = fold_add(acc, dst_port);
    acc = fold_add(acc, udp_len);
    w[W_UDP_CK] = (~acc == 16'h0000) ? ZERO_CK_SENT : ~acc;

    for (int k = 0; k < 14; k++) begin
      r.header_word   = w[k];
      r.word_index    = 4'(k);
      r.length_error  = ovf;
      r.end_of_header = (k == W_UDP_CK);
      header_words_due.push_back(r);
    end
    datagrams++;
    pay_sum = '0;
    nbytes  = '0;
    held_hi = '0;
    odd_pos = 1'b0;
    ovf     = 1'b0;
  endtask

  // typed values replace the predicted ones for the datagram just queued
  task automatic pin_expectation(plan_row_t row);
    int      base;
    result_t r;
    base = header_words_due.size() - 14;
    for (int k = 0; k < 14; k++) begin
      r = header_words_due[base + k];
      r.length_error = row.pin_lerr;
      if (r.word_index == row.pin_index) r.header_word = row.pin_word;
      header_words_due[base + k] = r;
    end
  endtask

  task automatic send_byte(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    absorb_byte(it);
  endtask

  task automatic send_datagram(int len);
    item_t it;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(7))
        0:       it.payload_byte = 8'h00;
        1:       it.payload_byte = 8'hFF;
        default: it.payload_byte = 8'($urandom);
      endcase
      it.final_byte = (k == len - 1);
      send_byte(it);
    end
  endtask

  // sender stops and waits for every header word, then lets the back end go quiet
  task automatic settle();
    push <= 1'b0;
    while (header_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    case (idx)
      REG_SOURCE_ADDRESS:      src_addr = d;
      REG_DESTINATION_ADDRESS: dst_addr = d;
      REG_SOURCE_PORT:         src_port = d[15:0];
      REG_DESTINATION_PORT:    dst_port = d[15:0];
      REG_TIME_TO_LIVE:        ttl      = d[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [31:0] sa, logic [31:0] da, logic [31:0] sp,
                               logic [31:0] dp, logic [31:0] tl);
    put_reg(REG_SOURCE_ADDRESS, sa);
    put_reg(REG_DESTINATION_ADDRESS, da);
    put_reg(REG_SOURCE_PORT, sp);
    put_reg(REG_DESTINATION_PORT, dp);
    put_reg(REG_TIME_TO_LIVE, tl);
    // unmapped index must leave everything alone
    put_reg(REG_UNUSED_FIRST + CFG_INDEX_W'($urandom_range(2)), $urandom);
    cfg_write <= 1'b0;
  endtask

  task automatic check_word(result_t got);
    result_t want;
    if (header_words_due.size() == 0) begin
      $error("unexpected header word %h at index %0d", got.header_word, got.word_index);
      fail_count++;
      return;
    end
    want = header_words_due.pop_front();
    words_checked++;
    if (got.header_word !== want.header_word) begin
      $error("header_word: expected %h, got %h", want.header_word, got.header_word);
      fail_count++;
    end
    if (got.word_index !== want.word_index) begin
      $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
      fail_count++;
    end
    if (got.length_error !== want.length_error) begin
      $error("length_error: expected %b, got %b", want.length_error, got.length_error);
      fail_count++;
    end
    if (got.end_of_header !== want.end_of_header) begin
      $error("end_of_header: expected %b, got %b", want.end_of_header, got.end_of_header);
      fail_count++;
    end
  endtask

  // receive side: random stalls plus a single long hold-off in the last phase
  initial begin
    int hold_seen = 0;
    int hold_left = 0;
    forever begin
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
      @(posedge clk);
      if (!rst && pop && !empty) check_word(result);
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("cycle limit hit with %0d header words outstanding", header_words_due.size());
    $display("testbench: errors");
    $finish;
  end

  initial begin
    item_t it;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed plan under reset settings
    foreach (PLAN[i]) begin
      for (int unsigned r = 0; r < PLAN[i].reps; r++) begin
        it.payload_byte = PLAN[i].value;
        it.final_byte   = PLAN[i].last && (r == PLAN[i].reps - 1);
        send_byte(it);
      end
      if (PLAN[i].last && PLAN[i].pinned) pin_expectation(PLAN[i]);
    end

    for (int ph = 0; ph < 5; ph++) begin
      int phase_bytes;
      int len;
      settle();
      case (ph)
        0:       load_settings('0, '0, '0, '0, '0);
        1:       load_settings('1, '1, '1, '1, '1);
        default: load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      case (ph)
        0:       begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct <= 55; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct <= 0;  rx_stall_pct <= 55; end
        3:       begin tx_idle_pct <= 25; rx_stall_pct <= 25; end
        default: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  hold_ticket <= hold_ticket + 1; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if (ph == 4) len = $urandom_range(1, 3);  // short beats fill the job queue
        else if ($urandom_range(99) < 8) len = $urandom_range(30, 60);
        else len = $urandom_range(1, 20);
        if (len > PHASE_BYTES - phase_bytes) len = PHASE_BYTES - phase_bytes;
        send_datagram(len);
        phase_bytes += len;
      end
    end
    settle();

    $display("covered %0d datagrams, %0d payload bytes, %0d header words checked",
             datagrams, bytes_sent, words_checked);
    $display("settings: reset, all-zero, all-ones, random; zero checksum, odd lengths, long hold-off");
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
